FILE: rtl/irft_pkg.sv
// Shared types and constants of the IPv4 range filter table.
package irft_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SW = AW + 2;

  localparam logic [7:0] FILTER_LEVEL_RST = 8'd127;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_FINALIZE = 2'd1,
    OP_LOOKUP   = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_READY = 2'd2
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] range_start;
    logic [31:0] range_end;
    logic [7:0]  range_level;
    logic [31:0] lookup_address;
  } cmd_t;

  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    logic [7:0]  level;
    logic [31:0] hits;
  } rec_t;

  localparam int unsigned RW = $bits(rec_t);

  typedef struct packed {
    status_e     status;
    logic        filtered;
    logic [11:0] entry_index;
    logic [31:0] entry_hits;
    logic [12:0] entry_count;
    logic [11:0] merged_count;
    logic [11:0] duplicate_count;
  } res_t;

endpackage

FILE: rtl/ip_range_filter_table.sv
// Top level of the IPv4 address-range filter table.
//
// Items take a variable number of cycles. An insert or clear is done in the
// execute state; a lookup is a binary search in which each probe is one
// registered RAM read followed by one compare. Finalize is a bottom-up merge
// sort between two RAM banks, one pass per doubling of the run width, then a
// compaction sweep that reads each element and compares it with the last kept
// one; the single read port of each bank sets this pace. The front end queues
// up to two items, so a new item is taken while the back end works or a result
// waits on a stalled output.
module ip_range_filter_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: filter_level
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] range_start_i,
  input  logic [31:0] range_end_i,
  input  logic [7:0]  range_level_i,
  input  logic [31:0] lookup_address_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        filtered_o,
  output logic [11:0] entry_index_o,
  output logic [31:0] entry_hits_o,
  output logic [12:0] entry_count_o,
  output logic [11:0] merged_count_o,
  output logic [11:0] duplicate_count_o
);

  logic [7:0]     filter_level_q;
  logic           cmd_valid, cmd_pop;
  irft_pkg::cmd_t cmd;
  irft_pkg::res_t res;

  // filter level register; to be written only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_level_q <= irft_pkg::FILTER_LEVEL_RST;
    end else if (cfg_we_i) begin
      filter_level_q <= cfg_wdata_i;
    end
  end

  // decode and queue
  irft_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .range_start_i   (range_start_i),
    .range_end_i     (range_end_i),
    .range_level_i   (range_level_i),
    .lookup_address_i(lookup_address_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  // table sequencer with its two RAM banks and output register
  irft_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .filter_level_i(filter_level_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .res_o         (res)
  );

  assign status_o          = res.status;
  assign filtered_o        = res.filtered;
  assign entry_index_o     = res.entry_index;
  assign entry_hits_o      = res.entry_hits;
  assign entry_count_o     = res.entry_count;
  assign merged_count_o    = res.merged_count;
  assign duplicate_count_o = res.duplicate_count;

endmodule

FILE: rtl/irft_ram.sv
// Generic single-write, single-read RAM with registered read data.
module irft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/irft_front.sv
// Front end: accepts input items, decodes them into commands, two-entry queue.
module irft_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     action_i,
  input  logic [31:0]    range_start_i,
  input  logic [31:0]    range_end_i,
  input  logic [7:0]     range_level_i,
  input  logic [31:0]    lookup_address_i,
  output logic           cmd_valid_o,
  output irft_pkg::cmd_t cmd_o,
  input  logic           cmd_pop_i
);

  irft_pkg::cmd_t mem_q [2];
  irft_pkg::cmd_t cmd_in;
  logic           wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  always_comb begin
    cmd_in.op             = irft_pkg::op_e'(action_i);
    cmd_in.range_start    = range_start_i;
    cmd_in.range_end      = range_end_i;
    cmd_in.range_level    = range_level_i;
    cmd_in.lookup_address = lookup_address_i;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wptr_d = push ? !wptr_q : wptr_q;
    rptr_d = pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/irft_back.sv
// Back end: sequencer for insert, merge sort, compaction, search and clear.
module irft_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     filter_level_i,
  input  logic           cmd_valid_i,
  input  irft_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output irft_pkg::res_t res_o
);

  localparam int unsigned AW  = irft_pkg::AW;
  localparam int unsigned CW  = irft_pkg::CW;
  localparam int unsigned SW  = irft_pkg::SW;
  localparam int unsigned RWB = irft_pkg::RW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_SRUN   = 4'd2;
  localparam logic [3:0] S_SLW    = 4'd3;
  localparam logic [3:0] S_SRW    = 4'd4;
  localparam logic [3:0] S_SMRG   = 4'd5;
  localparam logic [3:0] S_SWAIT  = 4'd6;
  localparam logic [3:0] S_CSTART = 4'd7;
  localparam logic [3:0] S_CFIRST = 4'd8;
  localparam logic [3:0] S_CRD    = 4'd9;
  localparam logic [3:0] S_CCMP   = 4'd10;
  localparam logic [3:0] S_LPROBE = 4'd11;
  localparam logic [3:0] S_LCMP   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]      state_q, state_d;
  logic [CW-1:0]   used_q, used_d;
  logic            ready_q, ready_d;
  logic            sb_q, sb_d;
  logic            out_valid_q, out_valid_d;

  irft_pkg::cmd_t  cmd_q, cmd_d;
  logic [SW-1:0]   width_q, width_d, lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [SW-1:0]   l_q, l_d, r_q, r_d, k_q, k_d;
  irft_pkg::rec_t  headl_q, headl_d, headr_q, headr_d, prev_q, prev_d;
  logic            wsel_q, wsel_d;
  logic [CW-1:0]   w_q, w_d, i_q, i_d, slo_q, slo_d, shi_q, shi_d, smid_q, smid_d;
  logic [CW-1:0]   mcnt_q, mcnt_d, dcnt_q, dcnt_d;
  irft_pkg::status_e p_status_q, p_status_d;
  logic            p_filt_q, p_filt_d;
  logic [31:0]     p_hits_q, p_hits_d;
  irft_pkg::res_t  res_q, res_d;

  logic            wr_en, wr_bank;
  logic [AW-1:0]   wr_addr, rd_addr;
  irft_pkg::rec_t  wr_data, rdata, rdata_a, rdata_b, cur, hit_rec;
  logic [RWB-1:0]  rdata_a_raw, rdata_b_raw;

  logic [SW-1:0]   n_s, run_m, run_h, lo_next, width_next;
  logic            lav, rav, takel, ov, adj;
  logic [CW-1:0]   probe_mid;
  logic [31:0]     hits_new;

  irft_ram #(.WIDTH(RWB), .DEPTH(irft_pkg::TABLE_DEPTH)) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (wr_en && !wr_bank),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rdata_a_raw)
  );

  irft_ram #(.WIDTH(RWB), .DEPTH(irft_pkg::TABLE_DEPTH)) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (wr_en && wr_bank),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rdata_b_raw)
  );

  assign rdata_a     = irft_pkg::rec_t'(rdata_a_raw);
  assign rdata_b     = irft_pkg::rec_t'(rdata_b_raw);
  assign rdata       = sb_q ? rdata_b : rdata_a;
  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    n_s        = SW'(used_q);
    run_m      = ((lo_q + width_q) < n_s) ? (lo_q + width_q) : n_s;
    run_h      = ((lo_q + (width_q << 1)) < n_s) ? (lo_q + (width_q << 1)) : n_s;
    lo_next    = lo_q + (width_q << 1);
    width_next = width_q << 1;
    lav        = l_q < mid_q;
    rav        = r_q < hi_q;
    takel      = lav && (!rav || (headl_q.start_addr <= headr_q.start_addr));
    cur        = rdata;
    ov         = (cur.start_addr >= prev_q.start_addr) && (cur.start_addr <= prev_q.end_addr);
    adj        = (({1'b0, prev_q.end_addr} + 33'd1) == {1'b0, cur.start_addr}) &&
                 (cur.level == prev_q.level);
    probe_mid  = slo_q + ((shi_q - slo_q) >> 1);
    hits_new   = (rdata.hits == 32'hFFFF_FFFF) ? rdata.hits : rdata.hits + 32'd1;
    hit_rec    = rdata;
    hit_rec.hits = hits_new;
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    ready_d     = ready_q;
    sb_d        = sb_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_d       = cmd_q;
    width_d     = width_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    l_d         = l_q;
    r_d         = r_q;
    k_d         = k_q;
    headl_d     = headl_q;
    headr_d     = headr_q;
    prev_d      = prev_q;
    wsel_d      = wsel_q;
    w_d         = w_q;
    i_d         = i_q;
    slo_d       = slo_q;
    shi_d       = shi_q;
    smid_d      = smid_q;
    mcnt_d      = mcnt_q;
    dcnt_d      = dcnt_q;
    p_status_d  = p_status_q;
    p_filt_d    = p_filt_q;
    p_hits_d    = p_hits_q;
    res_d       = res_q;
    wr_en       = 1'b0;
    wr_bank     = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    rd_addr     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        p_status_d = irft_pkg::ST_OK;
        p_filt_d   = 1'b0;
        p_hits_d   = '0;
        smid_d     = '0;
        mcnt_d     = '0;
        dcnt_d     = '0;
        state_d    = S_DONE;
        unique case (cmd_q.op)
          irft_pkg::OP_INSERT: begin
            if (used_q >= CW'(irft_pkg::TABLE_DEPTH)) begin
              p_status_d = irft_pkg::ST_FULL;
            end else begin
              wr_en              = 1'b1;
              wr_addr            = used_q[AW-1:0];
              wr_data.start_addr = cmd_q.range_start;
              wr_data.end_addr   = cmd_q.range_end;
              wr_data.level      = cmd_q.range_level;
              wr_data.hits       = '0;
              used_d             = used_q + CW'(1);
              ready_d            = 1'b0;
            end
          end
          irft_pkg::OP_FINALIZE: begin
            if (used_q < CW'(2)) begin
              ready_d = 1'b1;
            end else begin
              width_d = SW'(1);
              lo_d    = '0;
              sb_d    = 1'b0;
              state_d = S_SRUN;
            end
          end
          irft_pkg::OP_LOOKUP: begin
            if (!ready_q) begin
              p_status_d = irft_pkg::ST_NOT_READY;
            end else if (used_q != '0 && cmd_q.lookup_address != '0) begin
              slo_d   = '0;
              shi_d   = used_q;
              state_d = S_LPROBE;
            end
          end
          default: begin
            used_d  = '0;
            ready_d = 1'b1;
          end
        endcase
      end
      S_SRUN: begin
        mid_d   = run_m;
        hi_d    = run_h;
        l_d     = lo_q;
        r_d     = run_m;
        k_d     = lo_q;
        rd_addr = lo_q[AW-1:0];
        state_d = S_SLW;
      end
      S_SLW: begin
        headl_d = rdata;
        rd_addr = r_q[AW-1:0];
        state_d = S_SRW;
      end
      S_SRW: begin
        headr_d = rdata;
        state_d = S_SMRG;
      end
      S_SMRG: begin
        if (!lav && !rav) begin
          if (lo_next >= n_s) begin
            // pass complete: output bank becomes the source
            width_d = width_next;
            sb_d    = !sb_q;
            lo_d    = '0;
            state_d = (width_next >= n_s) ? S_CSTART : S_SRUN;
          end else begin
            lo_d    = lo_next;
            state_d = S_SRUN;
          end
        end else begin
          wr_en   = 1'b1;
          wr_bank = !sb_q;
          wr_addr = k_q[AW-1:0];
          wr_data = takel ? headl_q : headr_q;
          k_d     = k_q + SW'(1);
          if (takel) begin
            l_d     = l_q + SW'(1);
            rd_addr = l_d[AW-1:0];
            wsel_d  = 1'b0;
          end else begin
            r_d     = r_q + SW'(1);
            rd_addr = r_d[AW-1:0];
            wsel_d  = 1'b1;
          end
          state_d = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (wsel_q) begin
          headr_d = rdata;
        end else begin
          headl_d = rdata;
        end
        state_d = S_SMRG;
      end
      S_CSTART: begin
        rd_addr = '0;
        i_d     = CW'(1);
        w_d     = '0;
        state_d = S_CFIRST;
      end
      S_CFIRST: begin
        prev_d  = rdata;
        state_d = S_CRD;
      end
      S_CRD: begin
        if (i_q < used_q) begin
          rd_addr = i_q[AW-1:0];
          state_d = S_CCMP;
        end else begin
          wr_en   = 1'b1;
          wr_addr = w_q[AW-1:0];
          wr_data = prev_q;
          used_d  = w_q + CW'(1);
          ready_d = 1'b1;
          sb_d    = 1'b0;
          state_d = S_DONE;
        end
      end
      S_CCMP: begin
        if (ov || adj) begin
          if (cur.start_addr != prev_q.start_addr || cur.end_addr != prev_q.end_addr) begin
            if (cur.end_addr > prev_q.end_addr) begin
              prev_d.end_addr = cur.end_addr;
            end
            mcnt_d = mcnt_q + CW'(1);
          end else begin
            if (cur.level < prev_q.level) begin
              prev_d.level = cur.level;
            end
            dcnt_d = dcnt_q + CW'(1);
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = w_q[AW-1:0];
          wr_data = prev_q;
          w_d     = w_q + CW'(1);
          prev_d  = cur;
        end
        i_d     = i_q + CW'(1);
        state_d = S_CRD;
      end
      S_LPROBE: begin
        if (slo_q < shi_q) begin
          smid_d  = probe_mid;
          rd_addr = probe_mid[AW-1:0];
          state_d = S_LCMP;
        end else begin
          smid_d  = '0;
          state_d = S_DONE;
        end
      end
      S_LCMP: begin
        if (cmd_q.lookup_address < rdata.start_addr) begin
          shi_d   = smid_q;
          state_d = S_LPROBE;
        end else if (cmd_q.lookup_address > rdata.end_addr) begin
          slo_d   = smid_q + CW'(1);
          state_d = S_LPROBE;
        end else begin
          if (rdata.level < filter_level_i) begin
            wr_en    = 1'b1;
            wr_addr  = smid_q[AW-1:0];
            wr_data  = hit_rec;
            p_filt_d = 1'b1;
            p_hits_d = hits_new;
          end else begin
            smid_d = '0;
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          res_d.status          = p_status_q;
          res_d.filtered        = p_filt_q;
          res_d.entry_index     = p_filt_q ? 12'(smid_q) : 12'd0;
          res_d.entry_hits      = p_hits_q;
          res_d.entry_count     = 13'(used_q);
          res_d.merged_count    = 12'(mcnt_q);
          res_d.duplicate_count = 12'(dcnt_q);
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      ready_q     <= 1'b1;
      sb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      ready_q     <= ready_d;
      sb_q        <= sb_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    width_q    <= width_d;
    lo_q       <= lo_d;
    mid_q      <= mid_d;
    hi_q       <= hi_d;
    l_q        <= l_d;
    r_q        <= r_d;
    k_q        <= k_d;
    headl_q    <= headl_d;
    headr_q    <= headr_d;
    prev_q     <= prev_d;
    wsel_q     <= wsel_d;
    w_q        <= w_d;
    i_q        <= i_d;
    slo_q      <= slo_d;
    shi_q      <= shi_d;
    smid_q     <= smid_d;
    mcnt_q     <= mcnt_d;
    dcnt_q     <= dcnt_d;
    p_status_q <= p_status_d;
    p_filt_q   <= p_filt_d;
    p_hits_q   <= p_hits_d;
    res_q      <= res_d;
  end

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of the IPv4 address-range filter table.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // DUT ports
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = irft_pkg::OP_LOOKUP;
  logic [31:0] range_start_i = '0;
  logic [31:0] range_end_i = '0;
  logic [7:0]  range_level_i = '0;
  logic [31:0] lookup_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic        filtered_o;
  logic [11:0] entry_index_o;
  logic [31:0] entry_hits_o;
  logic [12:0] entry_count_o;
  logic [11:0] merged_count_o;
  logic [11:0] duplicate_count_o;

  ip_range_filter_table i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .action_i, .range_start_i, .range_end_i,
    .range_level_i, .lookup_address_i,
    .out_valid_o, .out_stall_i, .status_o, .filtered_o, .entry_index_o,
    .entry_hits_o, .entry_count_o, .merged_count_o, .duplicate_count_o
  );

  // Shadow copy of the table, kept in step with every accepted item
  logic [31:0] tbl_start [irft_pkg::TABLE_DEPTH];
  logic [31:0] tbl_end   [irft_pkg::TABLE_DEPTH];
  logic [7:0]  tbl_level [irft_pkg::TABLE_DEPTH];
  logic [31:0] tbl_hits  [irft_pkg::TABLE_DEPTH];
  int unsigned tbl_used;
  bit          tbl_ready;
  logic [7:0]  level_cutoff;

  irft_pkg::res_t expected_q[$];
  int    error_cnt;
  int    result_cnt;
  int    items_sent;
  int    filtered_seen;
  bit    hold_out;      // long receiver hold-off request

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_cnt++;
    $display("ERROR %0t: result %0d %s got 0x%0h want 0x%0h",
             $realtime, result_cnt, what, got, want);
  endtask

  // Stable sort by start, then merge overlapping / same-level adjacent ranges
  task automatic finalize_table(output int unsigned merged, output int unsigned dups);
    logic [31:0] s_tmp [$];
    logic [31:0] e_tmp [$];
    logic [7:0]  l_tmp [$];
    logic [31:0] h_tmp [$];
    int unsigned w;
    int          j;
    bit          ovl, adj;
    merged = 0;
    dups = 0;
    if (tbl_used >= 2) begin
      // insertion sort is stable: shift only strictly greater starts
      for (int i = 0; i < tbl_used; i++) begin
        j = s_tmp.size();
        while (j > 0 && s_tmp[j-1] > tbl_start[i]) j--;
        s_tmp.insert(j, tbl_start[i]);
        e_tmp.insert(j, tbl_end[i]);
        l_tmp.insert(j, tbl_level[i]);
        h_tmp.insert(j, tbl_hits[i]);
      end
      for (int i = 0; i < tbl_used; i++) begin
        tbl_start[i] = s_tmp[i];
        tbl_end[i]   = e_tmp[i];
        tbl_level[i] = l_tmp[i];
        tbl_hits[i]  = h_tmp[i];
      end
      w = 0;
      for (int i = 1; i < tbl_used; i++) begin
        ovl = (tbl_start[i] >= tbl_start[w]) && (tbl_start[i] <= tbl_end[w]);
        adj = ({1'b0, tbl_end[w]} + 33'd1 == {1'b0, tbl_start[i]}) &&
              (tbl_level[i] == tbl_level[w]);
        if (ovl || adj) begin
          if (tbl_start[i] != tbl_start[w] || tbl_end[i] != tbl_end[w]) begin
            if (tbl_end[i] > tbl_end[w]) tbl_end[w] = tbl_end[i];
            merged++;
          end else begin
            if (tbl_level[i] < tbl_level[w]) tbl_level[w] = tbl_level[i];
            dups++;
          end
        end else begin
          w++;
          tbl_start[w] = tbl_start[i];
          tbl_end[w]   = tbl_end[i];
          tbl_level[w] = tbl_level[i];
          tbl_hits[w]  = tbl_hits[i];
        end
      end
      tbl_used = w + 1;
    end
    tbl_ready = 1'b1;
  endtask

  // Predict one result and advance the shadow table
  task automatic predict_result(input irft_pkg::op_e op, input logic [31:0] rs,
                                input logic [31:0] re, input logic [7:0] rl,
                                input logic [31:0] addr, output irft_pkg::res_t r);
    int unsigned lo, hi, mid, mg, dp;
    r = '0;
    r.status = irft_pkg::ST_OK;
    case (op)
      irft_pkg::OP_INSERT: begin
        if (tbl_used >= irft_pkg::TABLE_DEPTH) begin
          r.status = irft_pkg::ST_FULL;
        end else begin
          tbl_start[tbl_used] = rs;
          tbl_end[tbl_used]   = re;
          tbl_level[tbl_used] = rl;
          tbl_hits[tbl_used]  = '0;
          tbl_used++;
          tbl_ready = 1'b0;
        end
      end
      irft_pkg::OP_FINALIZE: begin
        finalize_table(mg, dp);
        r.merged_count = mg[11:0];
        r.duplicate_count = dp[11:0];
      end
      irft_pkg::OP_LOOKUP: begin
        if (!tbl_ready) begin
          r.status = irft_pkg::ST_NOT_READY;
        end else if (tbl_used != 0 && addr != 0) begin
          lo = 0;
          hi = tbl_used;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (addr < tbl_start[mid]) hi = mid;
            else if (addr > tbl_end[mid]) lo = mid + 1;
            else begin
              if (tbl_level[mid] < level_cutoff) begin
                if (tbl_hits[mid] != 32'hFFFF_FFFF) tbl_hits[mid]++;
                r.filtered = 1'b1;
                r.entry_index = mid[11:0];
                r.entry_hits = tbl_hits[mid];
              end
              break;
            end
          end
        end
      end
      default: begin
        tbl_used = 0;
        tbl_ready = 1'b1;
      end
    endcase
    r.entry_count = tbl_used[12:0];
  endtask

  // Offer one item; returns once it is accepted
  task automatic send_item(input irft_pkg::op_e op, input logic [31:0] rs,
                           input logic [31:0] re, input logic [7:0] rl,
                           input logic [31:0] addr);
    irft_pkg::res_t r;
    in_valid_i <= 1'b1;
    action_i <= op;
    range_start_i <= rs;
    range_end_i <= re;
    range_level_i <= rl;
    lookup_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    predict_result(op, rs, re, rl, addr, r);
    expected_q.push_back(r);
    items_sent++;
  endtask

  task automatic idle_cycles(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Wait until every result is in, then a margin for the back end to settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_level(input logic [7:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    level_cutoff = v;
  endtask

  // Check side: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    irft_pkg::res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_cnt++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        e = expected_q.pop_front();
        if (filtered_o) filtered_seen++;
        if (status_o != e.status)
          report_mismatch("status", 32'(status_o), 32'(e.status));
        if (filtered_o != e.filtered)
          report_mismatch("filtered", 32'(filtered_o), 32'(e.filtered));
        if (entry_index_o != e.entry_index)
          report_mismatch("entry_index", 32'(entry_index_o), 32'(e.entry_index));
        if (entry_hits_o != e.entry_hits)
          report_mismatch("entry_hits", entry_hits_o, e.entry_hits);
        if (entry_count_o != e.entry_count)
          report_mismatch("entry_count", 32'(entry_count_o), 32'(e.entry_count));
        if (merged_count_o != e.merged_count)
          report_mismatch("merged_count", 32'(merged_count_o), 32'(e.merged_count));
        if (duplicate_count_o != e.duplicate_count)
          report_mismatch("duplicate_count", 32'(duplicate_count_o),
                          32'(e.duplicate_count));
      end
    end
  end

  // Receiver stall pattern: quiet stretches, random stalls, and long hold-offs
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      if (hold_out) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_out = 1'b0;
      end else if (mode == 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(5, 40)) begin
          out_stall_i <= ($urandom_range(0, 99) < 35);
          @(posedge clk_i);
        end
      end
    end
  end

  // Directed rows: value given only where it is obvious, else predictor-checked
  typedef struct {
    irft_pkg::op_e     op;
    logic [31:0]       rs, re;
    logic [7:0]        rl;
    logic [31:0]       addr;
    bit                has_want;
    irft_pkg::status_e want_status;
    logic [12:0]       want_count;
  } row_t;

  row_t rows[$];
  logic [31:0] pool[$];

  function automatic row_t mk_row(input irft_pkg::op_e op, input logic [31:0] rs,
                                  input logic [31:0] re, input logic [7:0] rl,
                                  input logic [31:0] addr, input bit has_want,
                                  input irft_pkg::status_e st, input logic [12:0] cnt);
    row_t r;
    r.op          = op;
    r.rs          = rs;
    r.re          = re;
    r.rl          = rl;
    r.addr        = addr;
    r.has_want    = has_want;
    r.want_status = st;
    r.want_count  = cnt;
    return r;
  endfunction

  function automatic logic [31:0] rand_addr();
    // mostly addresses near existing range bounds, to hit edges
    if (pool.size() != 0 && $urandom_range(0, 3) != 0)
      return pool[$urandom_range(0, pool.size() - 1)] + $urandom_range(0, 2) - 1;
    return $urandom();
  endfunction

  task automatic random_set(input int n_ins, input int n_look);
    logic [31:0] s, e;
    pool.delete();
    for (int i = 0; i < n_ins; i++) begin
      s = ($urandom_range(0, 9) == 0) ? $urandom() :
          {8'($urandom_range(0, 255)), 24'h0} + 32'($urandom_range(0, 1 << 20));
      case ($urandom_range(0, 5))
        0: e = s;
        1: e = s - 1;                                    // start above end
        2: e = (pool.size() != 0) ? pool[$] : s + 100;   // overlap/dup bait
        default: e = s + $urandom_range(0, 1 << 18);
      endcase
      if (e < s && $urandom_range(0, 3) != 0) e = s;
      pool.push_back(s);
      pool.push_back(e);
      send_item(irft_pkg::OP_INSERT, s, e, 8'($urandom_range(0, 255)), $urandom());
      if ($urandom_range(0, 5) == 0) begin     // adjacent neighbor, same or other level
        send_item(irft_pkg::OP_INSERT, e + 1, e + $urandom_range(1, 500),
                  $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)), $urandom());
        i++;
      end
      if ($urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 12));
    end
    if ($urandom_range(0, 9) == 0)
      send_item(irft_pkg::OP_LOOKUP, $urandom(), $urandom(), 8'($urandom()), rand_addr());
    send_item(irft_pkg::OP_FINALIZE, $urandom(), $urandom(), 8'($urandom()), $urandom());
    for (int i = 0; i < n_look; i++) begin
      send_item(irft_pkg::OP_LOOKUP, $urandom(), $urandom(), 8'($urandom()),
                ($urandom_range(0, 30) == 0) ? 32'h0 : rand_addr());
      if ($urandom_range(0, 5) == 0) idle_cycles($urandom_range(1, 20));
    end
  endtask

  // Stimulus
  initial begin
    row_t rw;
    logic [7:0] levels[4];
    levels = '{8'd0, 8'd255, 8'd1, 8'd200};
    tbl_used = 0;
    tbl_ready = 1'b1;
    level_cutoff = irft_pkg::FILTER_LEVEL_RST;
    hold_out = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    // empty table, finalize of an empty table
    rows.push_back(mk_row(irft_pkg::OP_LOOKUP, 32'h0, 32'h0, 8'd0, 32'h0A00_0001,
                          1'b1, irft_pkg::ST_OK, 13'd0));
    rows.push_back(mk_row(irft_pkg::OP_FINALIZE, 32'h0, 32'h0, 8'd0, 32'h0,
                          1'b1, irft_pkg::ST_OK, 13'd0));
    rows.push_back(mk_row(irft_pkg::OP_INSERT, 32'h0A00_0000, 32'h0A00_00FF, 8'd10, 32'h0,
                          1'b1, irft_pkg::ST_OK, 13'd1));
    // lookup before finalize
    rows.push_back(mk_row(irft_pkg::OP_LOOKUP, 32'h0, 32'h0, 8'd0, 32'h0A00_0001,
                          1'b1, irft_pkg::ST_NOT_READY, 13'd1));
    // adjacent, duplicate, top, bottom, start above end, overlap
    rows.push_back(mk_row(irft_pkg::OP_INSERT, 32'h0A00_0100, 32'h0A00_01FF, 8'd10, 32'h0,
                          1'b1, irft_pkg::ST_OK, 13'd2));
    rows.push_back(mk_row(irft_pkg::OP_INSERT, 32'h0A00_0000, 32'h0A00_00FF, 8'd3, 32'h0,
                          1'b1, irft_pkg::ST_OK, 13'd3));
    rows.push_back(mk_row(irft_pkg::OP_INSERT, 32'hFFFF_FF00, 32'hFFFF_FFFF, 8'd0, 32'h0,
                          1'b1, irft_pkg::ST_OK, 13'd4));
    rows.push_back(mk_row(irft_pkg::OP_INSERT, 32'h0, 32'h0000_00FF, 8'd0, 32'h0,
                          1'b1, irft_pkg::ST_OK, 13'd5));
    rows.push_back(mk_row(irft_pkg::OP_INSERT, 32'h2000_0000, 32'h1000_0000, 8'd0, 32'h0,
                          1'b1, irft_pkg::ST_OK, 13'd6));
    rows.push_back(mk_row(irft_pkg::OP_INSERT, 32'h3000_0000, 32'h3000_0FFF, 8'd255, 32'h0,
                          1'b1, irft_pkg::ST_OK, 13'd7));
    rows.push_back(mk_row(irft_pkg::OP_INSERT, 32'h3000_0800, 32'h3000_2000, 8'd1, 32'h0,
                          1'b1, irft_pkg::ST_OK, 13'd8));
    // finalize twice, then lookups: zero, hits, top, level 255 range, miss
    rows.push_back(mk_row(irft_pkg::OP_FINALIZE, 32'h0, 32'h0, 8'd0, 32'h0,
                          1'b0, irft_pkg::ST_OK, 13'd0));
    rows.push_back(mk_row(irft_pkg::OP_FINALIZE, 32'h0, 32'h0, 8'd0, 32'h0,
                          1'b0, irft_pkg::ST_OK, 13'd0));
    rows.push_back(mk_row(irft_pkg::OP_LOOKUP, 32'h0, 32'h0, 8'd0, 32'h0,
                          1'b0, irft_pkg::ST_OK, 13'd0));
    rows.push_back(mk_row(irft_pkg::OP_LOOKUP, 32'h0, 32'h0, 8'd0, 32'h0000_0010,
                          1'b0, irft_pkg::ST_OK, 13'd0));
    rows.push_back(mk_row(irft_pkg::OP_LOOKUP, 32'h0, 32'h0, 8'd0, 32'h0A00_0150,
                          1'b0, irft_pkg::ST_OK, 13'd0));
    rows.push_back(mk_row(irft_pkg::OP_LOOKUP, 32'h0, 32'h0, 8'd0, 32'h0A00_0150,
                          1'b0, irft_pkg::ST_OK, 13'd0));
    rows.push_back(mk_row(irft_pkg::OP_LOOKUP, 32'h0, 32'h0, 8'd0, 32'hFFFF_FFFF,
                          1'b0, irft_pkg::ST_OK, 13'd0));
    rows.push_back(mk_row(irft_pkg::OP_LOOKUP, 32'h0, 32'h0, 8'd0, 32'h3000_1000,
                          1'b0, irft_pkg::ST_OK, 13'd0));
    rows.push_back(mk_row(irft_pkg::OP_LOOKUP, 32'h0, 32'h0, 8'd0, 32'h1800_0000,
                          1'b0, irft_pkg::ST_OK, 13'd0));
    // clear, then a lookup on the empty table
    rows.push_back(mk_row(irft_pkg::OP_CLEAR, 32'h0, 32'h0, 8'd0, 32'h0,
                          1'b1, irft_pkg::ST_OK, 13'd0));
    rows.push_back(mk_row(irft_pkg::OP_LOOKUP, 32'h0, 32'h0, 8'd0, 32'h0A00_0001,
                          1'b1, irft_pkg::ST_OK, 13'd0));
    foreach (rows[i]) begin
      rw = rows[i];
      send_item(rw.op, rw.rs, rw.re, rw.rl, rw.addr);
      if (rw.has_want && (expected_q[$].status != rw.want_status ||
                          expected_q[$].entry_count != rw.want_count))
        report_mismatch("directed row", 32'(i), 32'(rw.want_count));
    end
    drain();

    // Random part, across filter_level settings including the extremes
    for (int ph = 0; ph < 16; ph++) begin
      write_level(ph < 4 ? levels[ph] : 8'($urandom_range(0, 255)));
      if (ph == 3) hold_out = 1'b1;            // long output hold-off while we push
      random_set($urandom_range(2, 30), $urandom_range(30, 70));
      if ($urandom_range(0, 1))
        send_item(irft_pkg::OP_CLEAR, $urandom(), $urandom(), 8'($urandom()), $urandom());
      if (ph == 6) drain();                    // sender pause until all is in
    end
    drain();

    $display("Covered %0d items (%0d filtered lookups) over 16 filter_level settings,",
             items_sent, filtered_seen);
    $display("including duplicates, adjacency, address space edges and unsorted inserts.");
    if (error_cnt == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
